### rtl/fdes_pkg.sv
package fdes_pkg;

   localparam int Depth      = 64;
   localparam int DataWidth  = 32;
   localparam int AddrWidth  = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   // operation codes
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_FLIP = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           mode;
      logic [DataWidth-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0]  popped_value;
      logic [1:0]            status;
      logic [CountWidth-1:0] item_count;
      logic                  is_flipped;
      logic                  store_empty;
      logic                  store_full;
   } rsp_type;

   // result of one operation, waiting for the memory read
   typedef struct packed {
      logic                  pop_ok;
      logic [1:0]            status;
      logic [CountWidth-1:0] item_count;
      logic                  is_flipped;
      logic                  store_empty;
      logic                  store_full;
   } stage_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] wr_data;
   } mem_req_type;

endpackage

### rtl/flippable_double_ended_stack.sv
// flippable double-ended stack: two stacks share one 64-entry store, the front
// stack growing up from entry 0 and the back stack growing down from the top
//
// req channel: req_valid / req_stall / req_data carry one item (mode, push_value);
//   mode push stores at the active end, pop removes its top, flip swaps ends
// rsp channel: rsp_valid / rsp_stall / rsp_data return exactly one item per
//   request, in order: popped value, status, count and the end/empty/full flags
//
// timing: the pointer update and the memory access happen at the edge that accepts an
//   item; its status waits in the memory stage, and the memory's registered read data
//   is folded into the output register once that register is free, from which rsp
//   presents the item
// throughput: one item per cycle while rsp_stall is low, set by the single port of the
//   element memory (each item does at most one read or one write)
//
// when rsp_stall holds, the output register keeps its item and one more item
//   waits in the memory stage; after that req_stall rises until rsp drains
// reset clears the pointers, the count and the flip flag and drops every item
//   in flight; the element memory keeps its contents and is never cleared
module flippable_double_ended_stack (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fdes_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fdes_pkg::rsp_type rsp_data
);

   // handshake control
   logic accept;
   logic out_free;
   logic s1_move;

   // memory stage
   logic                           s1_valid_ff, s1_valid_in;
   fdes_pkg::stage_type            s1_ff;
   fdes_pkg::stage_type            stage;
   fdes_pkg::mem_req_type          mem_req;
   logic [fdes_pkg::DataWidth-1:0] rd_data;

   // output register
   logic              out_valid_ff, out_valid_in;
   fdes_pkg::rsp_type out_ff, out_in;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   fdes_ptr u_ptr (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .mem_req (mem_req),
      .stage   (stage)
   );

   fdes_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // memory stage holds the status until the read data is back
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
   end

   // popped value is zero unless the pop succeeded
   always_comb begin
      out_in.popped_value = s1_ff.pop_ok ? rd_data : '0;
      out_in.status       = s1_ff.status;
      out_in.item_count   = s1_ff.item_count;
      out_in.is_flipped   = s1_ff.is_flipped;
      out_in.store_empty  = s1_ff.store_empty;
      out_in.store_full   = s1_ff.store_full;
   end

   always_comb begin
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // a failed operation never returns data
   a_no_data_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != fdes_pkg::ST_OK) |-> rsp_data.popped_value == '0)
      else $error("data returned with error status");

   // full flag agrees with the count
   a_full_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.store_full ==
         (rsp_data.item_count == fdes_pkg::CountWidth'(fdes_pkg::Depth)))
      else $error("full flag disagrees with count");

   // a blocked memory stage keeps its item
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("memory stage lost an item");

   // memory is never read and written in the same cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("memory read and write together");

endmodule

### rtl/fdes_mem.sv
module fdes_mem (
   input  logic                           clock,
   input  fdes_pkg::mem_req_type          mem_req,
   output logic [fdes_pkg::DataWidth-1:0] rd_data
);

   logic [fdes_pkg::DataWidth-1:0] mem [fdes_pkg::Depth];
   logic [fdes_pkg::DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fdes_ptr.sv
module fdes_ptr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  fdes_pkg::req_type     req,
   output fdes_pkg::mem_req_type mem_req,
   output fdes_pkg::stage_type   stage
);

   localparam int CW = fdes_pkg::CountWidth;
   localparam int AW = fdes_pkg::AddrWidth;

   logic [CW-1:0] front_ff, front_in;
   logic [CW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;
   logic          flip_ff, flip_in;

   logic          full_now;
   logic [CW-1:0] front_pop_slot;
   logic [CW-1:0] back_push_slot;
   logic [CW-1:0] back_pop_slot;
   logic [1:0]    status;
   logic          pop_ok;

   assign full_now       = (count_ff == CW'(fdes_pkg::Depth));
   assign front_pop_slot = front_ff - CW'(1);
   assign back_push_slot = CW'(fdes_pkg::Depth - 1) - back_ff;
   assign back_pop_slot  = CW'(fdes_pkg::Depth) - back_ff;

   always_comb begin
      front_in        = front_ff;
      back_in         = back_ff;
      count_in        = count_ff;
      flip_in         = flip_ff;
      status          = fdes_pkg::ST_OK;
      pop_ok          = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.addr    = front_ff[AW-1:0];
      mem_req.wr_data = req.push_value;
      case (req.mode)
         fdes_pkg::MODE_PUSH: begin
            if (full_now) begin
               status = fdes_pkg::ST_FULL;
            end else if (!flip_ff) begin
               mem_req.addr  = front_ff[AW-1:0];
               mem_req.wr_en = accept;
               front_in      = front_ff + CW'(1);
               count_in      = count_ff + CW'(1);
            end else begin
               mem_req.addr  = back_push_slot[AW-1:0];
               mem_req.wr_en = accept;
               back_in       = back_ff + CW'(1);
               count_in      = count_ff + CW'(1);
            end
         end
         fdes_pkg::MODE_POP: begin
            if (!flip_ff) begin
               if (front_ff == '0) begin
                  status = fdes_pkg::ST_EMPTY;
               end else begin
                  mem_req.addr  = front_pop_slot[AW-1:0];
                  mem_req.rd_en = accept;
                  pop_ok        = 1'b1;
                  front_in      = front_pop_slot;
                  count_in      = count_ff - CW'(1);
               end
            end else begin
               if (back_ff == '0) begin
                  status = fdes_pkg::ST_EMPTY;
               end else begin
                  mem_req.addr  = back_pop_slot[AW-1:0];
                  mem_req.rd_en = accept;
                  pop_ok        = 1'b1;
                  back_in       = back_ff - CW'(1);
                  count_in      = count_ff - CW'(1);
               end
            end
         end
         fdes_pkg::MODE_FLIP: begin
            flip_in = ~flip_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         flip_ff  <= 1'b0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         flip_ff  <= flip_in;
      end
   end

   assign stage.pop_ok      = pop_ok;
   assign stage.status      = status;
   assign stage.item_count  = count_in;
   assign stage.is_flipped  = flip_in;
   assign stage.store_empty = (count_in == '0);
   assign stage.store_full  = (count_in == CW'(fdes_pkg::Depth));

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // mode three has no package name, it is a plain no-op
   localparam logic [1:0] ModeIdle = 2'd3;

   localparam int RandomItems = 1300;
   localparam int QuietItems  = 200;
   localparam int CycleLimit  = 500000;
   localparam int DrainCycles = 20;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   fdes_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   fdes_pkg::rsp_type rsp_data;

   // one row of the directed table, want is only used when typed is set
   typedef struct {
      fdes_pkg::req_type req;
      bit                typed;
      fdes_pkg::rsp_type want;
   } directed_step;

   directed_step directed_steps[$];

   // shadow copy of the two stacks
   logic [fdes_pkg::DataWidth-1:0] shadow_mem [fdes_pkg::Depth];
   int                             front_used;
   int                             back_used;
   bit                             flipped;

   fdes_pkg::rsp_type expected_rsps[$];
   int                mismatch_count;
   int                rsp_seen;
   int                sent_count;
   bit                quiet_tail;
   bit                sender_idles;
   bit                drained_once;

   flippable_double_ended_stack dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // applies one operation to the shadow stacks and returns the item it must produce
   function automatic fdes_pkg::rsp_type stack_predict(input fdes_pkg::req_type r);
      fdes_pkg::rsp_type e;
      e = '0;
      e.status = fdes_pkg::ST_OK;
      case (r.mode)
         fdes_pkg::MODE_PUSH: begin
            if (front_used + back_used >= fdes_pkg::Depth) begin
               e.status = fdes_pkg::ST_FULL;
            end else if (!flipped) begin
               shadow_mem[fdes_pkg::AddrWidth'(front_used)] = r.push_value;
               front_used++;
            end else begin
               shadow_mem[fdes_pkg::AddrWidth'(fdes_pkg::Depth - 1 - back_used)] =
                  r.push_value;
               back_used++;
            end
         end
         fdes_pkg::MODE_POP: begin
            // only the active end counts, the other end may still hold items
            if (!flipped) begin
               if (front_used == 0) begin
                  e.status = fdes_pkg::ST_EMPTY;
               end else begin
                  front_used--;
                  e.popped_value = shadow_mem[fdes_pkg::AddrWidth'(front_used)];
               end
            end else begin
               if (back_used == 0) begin
                  e.status = fdes_pkg::ST_EMPTY;
               end else begin
                  e.popped_value =
                     shadow_mem[fdes_pkg::AddrWidth'(fdes_pkg::Depth - back_used)];
                  back_used--;
               end
            end
         end
         fdes_pkg::MODE_FLIP: begin
            flipped = !flipped;
         end
         default: begin
         end
      endcase
      e.item_count  = fdes_pkg::CountWidth'(front_used + back_used);
      e.is_flipped  = flipped;
      e.store_empty = (front_used + back_used == 0);
      e.store_full  = (front_used + back_used >= fdes_pkg::Depth);
      return e;
   endfunction

   // weights are out of 100, whatever is left over goes to the no-op mode
   function automatic fdes_pkg::req_type random_item(input int push_w, input int pop_w,
                                                     input int flip_w);
      fdes_pkg::req_type r;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < push_w) begin
         r.mode = fdes_pkg::MODE_PUSH;
      end else if (pick < push_w + pop_w) begin
         r.mode = fdes_pkg::MODE_POP;
      end else if (pick < push_w + pop_w + flip_w) begin
         r.mode = fdes_pkg::MODE_FLIP;
      end else begin
         r.mode = ModeIdle;
      end
      // corner values mixed in with plain random words
      case ($urandom_range(0, 7))
         0: begin
            r.push_value = '0;
         end
         1: begin
            r.push_value = '1;
         end
         2: begin
            r.push_value = fdes_pkg::DataWidth'(1) <<
                           $urandom_range(0, fdes_pkg::DataWidth - 1);
         end
         default: begin
            r.push_value = $urandom;
         end
      endcase
      return r;
   endfunction

   task automatic add_row(input logic [1:0] mode,
                          input logic [fdes_pkg::DataWidth-1:0] value,
                          input int typed, input logic [fdes_pkg::DataWidth-1:0] popped,
                          input logic [1:0] status, input int count,
                          input int is_flip, input int is_empty, input int is_full);
      directed_step s;
      s.req.mode             = mode;
      s.req.push_value       = value;
      s.typed                = (typed != 0);
      s.want.popped_value    = popped;
      s.want.status          = status;
      s.want.item_count      = fdes_pkg::CountWidth'(count);
      s.want.is_flipped      = (is_flip != 0);
      s.want.store_empty     = (is_empty != 0);
      s.want.store_full      = (is_full != 0);
      directed_steps.push_back(s);
   endtask

   // presents one item, holds it through stalls and records its expectation on accept
   task automatic send_item(input fdes_pkg::req_type r, input bit typed,
                            input fdes_pkg::rsp_type want);
      fdes_pkg::rsp_type predicted;
      if (sender_idles && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = stack_predict(r);
      expected_rsps.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic send_random(input int push_w, input int pop_w, input int flip_w);
      send_item(random_item(push_w, pop_w, flip_w), 1'b0, '0);
   endtask

   // receiver side: random stall bursts between free-running stretches
   initial begin
      int   hold;
      logic next_stall;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (quiet_tail) begin
            next_stall = 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            next_stall = rsp_stall;
            hold--;
         end else if ($urandom_range(0, 2) == 0) begin
            next_stall = 1'b1;
            hold = $urandom_range(0, 15);
         end else begin
            next_stall = 1'b0;
            hold = $urandom_range(0, 40);
         end
         rsp_stall <= next_stall;
      end
   end

   // every accepted result is checked against the oldest expectation
   always @(posedge clock) begin
      fdes_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("item %0d: no item expected, got value %h status %0d count %0d %b%b%b",
                        rsp_seen, rsp_data.popped_value, rsp_data.status,
                        rsp_data.item_count, rsp_data.is_flipped, rsp_data.store_empty,
                        rsp_data.store_full);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"item %0d: expected value %h status %0d count %0d flip %b ",
                            "empty %b full %b, got value %h status %0d count %0d flip %b ",
                            "empty %b full %b"},
                           rsp_seen, want.popped_value, want.status, want.item_count,
                           want.is_flipped, want.store_empty, want.store_full,
                           rsp_data.popped_value, rsp_data.status, rsp_data.item_count,
                           rsp_data.is_flipped, rsp_data.store_empty, rsp_data.store_full);
            end
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      int phase;
      int len;
      int flip_at;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      front_used     = 0;
      back_used      = 0;
      flipped        = 1'b0;
      mismatch_count = 0;
      rsp_seen       = 0;
      sent_count     = 0;
      quiet_tail     = 1'b0;
      sender_idles   = 1'b1;
      drained_once   = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part: empty pops on both ends, flips, extremes of the data,
      // no-op mode, pop of an empty end while the other end holds items
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_EMPTY, 0, 0, 1, 0);
      add_row(ModeIdle,            32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    0, 0, 1, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    0, 1, 1, 0);
      add_row(fdes_pkg::MODE_POP,  32'hFFFF_FFFF, 1, 32'h0,
              fdes_pkg::ST_EMPTY, 0, 1, 1, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    1, 1, 0, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1, 32'h0,
              fdes_pkg::ST_OK,    2, 1, 0, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    2, 0, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_EMPTY, 2, 0, 0, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'hA5A5_A5A5, 1, 32'h0,
              fdes_pkg::ST_OK,    3, 0, 0, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'h5A5A_5A5A, 1, 32'h0,
              fdes_pkg::ST_OK,    4, 0, 0, 0);
      add_row(ModeIdle,            32'hFFFF_FFFF, 1, 32'h0,
              fdes_pkg::ST_OK,    4, 0, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'h5A5A_5A5A,
              fdes_pkg::ST_OK,    3, 0, 0, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h1234_5678, 1, 32'h0,
              fdes_pkg::ST_OK,    3, 1, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'hFFFF_FFFF,
              fdes_pkg::ST_OK,    2, 1, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    1, 1, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_EMPTY, 1, 1, 0, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h0000_0000, 1, 32'h0,
              fdes_pkg::ST_OK,    1, 0, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 1, 32'hA5A5_A5A5,
              fdes_pkg::ST_OK,    0, 0, 1, 0);
      // the rest of the table goes through the predictor
      add_row(fdes_pkg::MODE_PUSH, 32'h8000_0000, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'h0000_0001, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h0000_0000, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_PUSH, 32'h7FFF_FFFF, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_FLIP, 32'h0000_0000, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);
      add_row(fdes_pkg::MODE_POP,  32'h0000_0000, 0, 32'h0, fdes_pkg::ST_OK, 0, 0, 0, 0);

      foreach (directed_steps[i])
         send_item(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);

      // random part, built from phases so that full and empty are reached often
      sent_count = 0;
      phase = 0;
      while (sent_count < RandomItems) begin
         sender_idles = ($urandom_range(0, 2) != 0);
         if (sent_count >= RandomItems - QuietItems)
            quiet_tail = 1'b1;
         case (phase)
            0: begin
               // fill to full, maybe switching ends part way, then push into a full store
               flip_at = $urandom_range(0, 1) ? $urandom_range(1, fdes_pkg::Depth - 1) : -1;
               len = 0;
               while (front_used + back_used < fdes_pkg::Depth) begin
                  if (len == flip_at)
                     send_item('{mode: fdes_pkg::MODE_FLIP, push_value: $urandom},
                               1'b0, '0);
                  else
                     send_random(100, 0, 0);
                  len++;
               end
               repeat ($urandom_range(1, 4)) send_random(100, 0, 0);
            end
            1: begin
               // drain the active end past empty, sometimes the other end too
               repeat ($urandom_range(1, 2)) begin
                  while ((flipped ? back_used : front_used) > 0) send_random(0, 100, 0);
                  repeat ($urandom_range(1, 4)) send_random(0, 100, 0);
                  send_item('{mode: fdes_pkg::MODE_FLIP, push_value: $urandom}, 1'b0, '0);
               end
            end
            2: begin
               repeat ($urandom_range(10, 40)) send_random(45, 40, 10);
            end
            3: begin
               repeat ($urandom_range(10, 30)) send_random(35, 35, 25);
            end
            default: begin
               // noise, no-op mode included
               repeat ($urandom_range(5, 15)) send_random(25, 25, 25);
            end
         endcase
         phase = $urandom_range(0, 4);

         // once, midway: let the pipeline drain completely before going on
         if (!drained_once && sent_count >= RandomItems / 2 && !quiet_tail) begin
            req_valid <= 1'b0;
            while (expected_rsps.size() != 0) @(posedge clock);
            drained_once = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
